### src/sacl_pkg.sv
// Shared payload types and fixed field widths of the cache tag controller.
package sacl_pkg;

  localparam int AddrW   = 26;
  localparam int WayOutW = 2;
  localparam int EvTagW  = 20;
  localparam int CntW    = 32;

  typedef struct packed {
    logic [AddrW-1:0] block_address;
    logic             is_write;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [WayOutW-1:0] way_used;
    logic              writeback_needed;
    logic [EvTagW-1:0] evicted_tag;
    logic [CntW-1:0]   hits_total;
    logic [CntW-1:0]   misses_total;
  } rsp_t;

endpackage

### src/sacl_ifs.sv
// Valid/ready channel interfaces for access requests and their results.
interface sacl_req_if;
  logic             valid;
  logic             ready;
  sacl_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sacl_rsp_if;
  logic             valid;
  logic             ready;
  sacl_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/set_assoc_lru_cache_tags_top.sv
// Tag, valid, dirty and LRU controller of a set-associative write-back cache.
//
//   channel  direction  payload                                     handshake
//   req_i    in         block_address, is_write                     valid/ready
//   rsp_o    out        hit, way_used, writeback_needed,            valid/ready
//                       evicted_tag, hits_total, misses_total
//
// Each request is handled in order: the block address is multiplied by the
// reciprocal of SETS as it is taken, set and tag are formed and both memories
// are read, and the ways are searched, the set updated and written back.
// After reset the metadata memory is swept once, one set per cycle, so no
// request is taken until the sweep has finished.
// A finished result waits in the output register while the next request is
// taken; only the lookup step stalls when that register is still full.
module set_assoc_lru_cache_tags_top #(
  parameter int SETS     = 64,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sacl_req_if.sink          req_i,
  sacl_rsp_if.source        rsp_o
);

  localparam int AddrW   = sacl_pkg::AddrW;
  localparam int SetL    = $clog2(SETS);
  localparam int SetW    = (SETS > 1) ? SetL : 1;
  localparam int WayW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  // Exact division of any address by SETS: multiply by a rounded-up
  // reciprocal that is one bit wider than the address, then shift.
  localparam int DivShift = AddrW + SetL;
  localparam int DivMulW  = AddrW + 1;
  localparam int ProdW    = AddrW + DivMulW;
  localparam logic [DivMulW-1:0] DivMul =
    DivMulW'(((64'd1 << DivShift) / SETS) + 1);

  typedef logic [WAYS-1:0][WayW-1:0]     order_t;
  typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;

  // One row of per-set metadata. Position 0 of the order is the most recent way.
  typedef struct packed {
    logic [WAYS-1:0] valid;
    logic [WAYS-1:0] dirty;
    order_t          order;
  } meta_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_LOOK
  } state_e;

  state_e                 state_q;
  logic                   clearing_q;
  logic [SetW-1:0]        clr_idx_q;
  logic [AddrW-1:0]       addr_q;
  logic                   wr_q;
  logic [ProdW-1:0]       prod_q;
  logic [SetW-1:0]        set_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic                   rsp_valid_q;
  sacl_pkg::rsp_t         rsp_q;
  logic [sacl_pkg::CntW-1:0] hits_q;
  logic [sacl_pkg::CntW-1:0] misses_q;

  // Memories: tags are never cleared, metadata is swept after reset.
  tag_row_t               tag_mem [SETS];
  meta_t                  meta_mem [SETS];
  tag_row_t               tag_rd_q;
  meta_t                  meta_rd_q;

  logic [ProdW-1:0]       prod_d;
  logic [AddrW-1:0]       quot;
  logic [AddrW-1:0]       rem;
  logic [SetW-1:0]        set_d;
  logic [TAG_BITS-1:0]    tag_d;

  logic [WAYS-1:0]        match;
  logic                   hit;
  logic [WayW-1:0]        hit_way;
  logic [WayW-1:0]        victim;
  logic [WayW-1:0]        way;
  logic [WayW-1:0]        pos;
  order_t                 order_new;
  meta_t                  meta_new;
  meta_t                  meta_rst;
  tag_row_t               tag_row_new;
  logic                   wb;
  logic [TAG_BITS-1:0]    ev_tag;

  logic                   out_free;
  logic                   look_done;
  logic                   meta_we;
  logic [SetW-1:0]        meta_waddr;
  meta_t                  meta_wdata;

  // Address split: quotient from the reciprocal product, remainder from it.
  assign prod_d = ProdW'(req_i.data.block_address) * ProdW'(DivMul);
  assign quot   = AddrW'(prod_q >> DivShift);
  assign rem    = addr_q - AddrW'(quot * SETS);
  assign set_d  = SetW'(rem);
  assign tag_d  = TAG_BITS'(quot);

  // Way search; tags of valid ways in a set are unique, lowest index wins anyway.
  always_comb begin
    match   = '0;
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = meta_rd_q.valid[w] && (tag_rd_q[w] == tag_q);
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
    end
  end

  assign victim = meta_rd_q.order[WAYS-1];
  assign way    = hit ? hit_way : victim;
  assign wb     = !hit && meta_rd_q.valid[victim] && meta_rd_q.dirty[victim];
  assign ev_tag = wb ? tag_rd_q[victim] : '0;

  // Move the used way to the front, shifting the ways ahead of it back by one.
  always_comb begin
    pos = WayW'(WAYS - 1);
    for (int p = 0; p < WAYS; p++) begin
      if (meta_rd_q.order[p] == way) begin
        pos = WayW'(p);
      end
    end
    order_new    = meta_rd_q.order;
    order_new[0] = way;
    for (int p = 1; p < WAYS; p++) begin
      if (WayW'(p) <= pos) begin
        order_new[p] = meta_rd_q.order[p-1];
      end
    end
  end

  always_comb begin
    meta_new       = meta_rd_q;
    meta_new.order = order_new;
    tag_row_new    = tag_rd_q;
    if (hit) begin
      if (wr_q) begin
        meta_new.dirty[way] = 1'b1;
      end
    end else begin
      meta_new.valid[way] = 1'b1;
      meta_new.dirty[way] = wr_q;
      tag_row_new[way]    = tag_q;
    end
  end

  always_comb begin
    meta_rst.valid = '0;
    meta_rst.dirty = '0;
    for (int p = 0; p < WAYS; p++) begin
      meta_rst.order[p] = WayW'(WAYS - 1 - p);
    end
  end

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign look_done = (state_q == S_LOOK) && out_free;

  assign meta_we    = clearing_q || look_done;
  assign meta_waddr = clearing_q ? clr_idx_q : set_q;
  assign meta_wdata = clearing_q ? meta_rst : meta_new;

  assign req_i.ready = (state_q == S_IDLE) && !clearing_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (state_q == S_DIV) begin
      meta_rd_q <= meta_mem[set_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_done && !hit) begin
      tag_mem[set_q] <= tag_row_new;
    end
    if (state_q == S_DIV) begin
      tag_rd_q <= tag_mem[set_d];
    end
  end

  // Request datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      addr_q <= req_i.data.block_address;
      wr_q   <= req_i.data.is_write;
      prod_q <= prod_d;
    end
    if (state_q == S_DIV) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  // Sequencer, clearing sweep, counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      rsp_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == SetW'(SETS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      // A result that leaves while a new one is loaded is replaced below.
      if (rsp_o.ready && !look_done) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          if (out_free) begin
            state_q                <= S_IDLE;
            rsp_valid_q            <= 1'b1;
            rsp_q.hit              <= hit;
            rsp_q.way_used         <= sacl_pkg::WayOutW'(way);
            rsp_q.writeback_needed <= wb;
            rsp_q.evicted_tag      <= sacl_pkg::EvTagW'(ev_tag);
            if (hit) begin
              hits_q               <= hits_q + 1'b1;
              rsp_q.hits_total     <= hits_q + 1'b1;
              rsp_q.misses_total   <= misses_q;
            end else begin
              misses_q             <= misses_q + 1'b1;
              rsp_q.hits_total     <= hits_q;
              rsp_q.misses_total   <= misses_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A tag is held by at most one valid way of a set.
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> $onehot0(match))
    else $error("more than one way matched the tag");

  // Every finished lookup advances exactly one of the two counters.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    look_done |=> (sacl_pkg::CntW'(hits_q + misses_q) ==
                   sacl_pkg::CntW'($past(hits_q) + $past(misses_q) + 1'b1)))
    else $error("counters did not advance by one");

  // A write-back is only reported for a miss.
  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_q.hit && rsp_q.writeback_needed))
    else $error("write-back reported on a hit");

  // The sweep after reset runs only while no request is in flight.
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (state_q == S_IDLE))
    else $error("request in flight during the clearing sweep");
`endif

endmodule
